[hdl/afbq_pkg.sv]
// shared types and codes for the audio frame buffer queue
`default_nettype none
package afbq_pkg;

  // request selector codes
  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_WORD  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_STALE    = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_NO_ROOM  = 3'd3;
  localparam logic [2:0] ST_FRAME    = 3'd4;

  // media position scale, microseconds per second
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam int          DIVIDEND_W = 38;
  localparam int          RATE_W = 19;

  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 192;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic word_write;
    logic enq_do;
    logic flush_do;
    logic read_start;
    logic drop;
    logic div_start;
    logic pos_set;
    logic fetch_b;
    logic frame_wr;
    logic rd_end;
    logic emit_rd;
    logic emit_load;
  } afbq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       read_nothing;
    logic       rd_done;
    logic       head_match;
    logic       first_copy;
    logic       div_done;
    logic       out_free;
    logic       emit_last;
  } afbq_stat_t;

endpackage
`default_nettype wire

[hdl/afbq_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none
module afbq_div
  import afbq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [RATE_W-1:0]     divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [RATE_W-1:0] rem_r;
  logic [RATE_W-1:0] dvs_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [RATE_W:0]   trial;
  logic              fits;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // payload of the division
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? RATE_W'(trial - {1'b0, dvs_r}) : RATE_W'(trial);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

[hdl/afbq_ctrl.sv]
// sequencing state machine of the audio frame buffer queue
`default_nettype none
module afbq_ctrl
  import afbq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire afbq_stat_t stat,
  output afbq_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WORD  = 4'd1;
  localparam logic [3:0] S_ENQ   = 4'd2;
  localparam logic [3:0] S_FLS   = 4'd3;
  localparam logic [3:0] S_RCHK  = 4'd4;
  localparam logic [3:0] S_LOOK  = 4'd5;
  localparam logic [3:0] S_HEAD  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_RA    = 4'd8;
  localparam logic [3:0] S_RB    = 4'd9;
  localparam logic [3:0] S_WR    = 4'd10;
  localparam logic [3:0] S_END   = 4'd11;
  localparam logic [3:0] S_EMRD  = 4'd12;
  localparam logic [3:0] S_EMOUT = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        case (stat.cmd)
          CMD_ENQ:   state_nxt = S_ENQ;
          CMD_WORD:  state_nxt = S_WORD;
          CMD_FLUSH: state_nxt = S_FLS;
          default: begin
            cmd.read_start = 1'b1;
            state_nxt = stat.read_nothing ? S_IDLE : S_LOOK;
          end
        endcase
      end
      S_WORD: begin
        cmd.word_write = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ENQ: begin
        if (stat.out_free) begin
          cmd.enq_do = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FLS: begin
        if (stat.out_free) begin
          cmd.flush_do = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LOOK: state_nxt = S_HEAD;
      S_HEAD: begin
        if (stat.rd_done) begin
          state_nxt = S_END;
        end else if (!stat.head_match) begin
          cmd.drop = 1'b1;
          state_nxt = S_LOOK;
        end else if (stat.first_copy) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_RA;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.pos_set = 1'b1;
          state_nxt = S_RA;
        end
      end
      S_RA: state_nxt = S_RB;
      S_RB: begin
        cmd.fetch_b = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.frame_wr = 1'b1;
        state_nxt = S_LOOK;
      end
      S_END: begin
        cmd.rd_end = 1'b1;
        state_nxt = S_EMRD;
      end
      S_EMRD: begin
        cmd.emit_rd = 1'b1;
        state_nxt = S_EMOUT;
      end
      S_EMOUT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt = stat.emit_last ? S_IDLE : S_EMRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/afbq_datapath.sv]
// buffer tables, sample store, frame buffer and result register
`default_nettype none
module afbq_datapath
  import afbq_pkg::*;
#(
  parameter int ENTRY_DEPTH  = 16,
  parameter int STORE_WORDS  = 262144,
  parameter int MAX_CHANNELS = 2,
  parameter int READ_FRAMES  = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]            in_tuser,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_wr_en,
  input  wire logic [17:0]           cfg_wr_data,
  input  wire afbq_cmd_t             cmd,
  output afbq_stat_t                 stat
);

  localparam int EIW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int EUW = $clog2(ENTRY_DEPTH + 1);
  localparam int SAW = $clog2(STORE_WORDS);
  localparam int SUW = $clog2(STORE_WORDS + 1);
  localparam int FBW = (READ_FRAMES > 1) ? $clog2(READ_FRAMES) : 1;

  // latched request
  logic [1:0]  cmd_r;
  logic [63:0] gen_r;
  logic [17:0] fc_r;
  logic [1:0]  ch_r;
  logic [23:0] bytes_r;
  logic [18:0] rate_r;
  logic [63:0] pts_r;
  logic [31:0] word_r;
  logic [6:0]  n_r;

  // queue state
  logic [17:0]    max_r;
  logic [EIW-1:0] head_r;
  logic [EUW-1:0] used_r;
  logic [SAW-1:0] wptr_r;
  logic [SAW-1:0] rptr_r;
  logic [17:0]    queued_r;
  logic [31:0]    pending_r;
  logic [SUW-1:0] uwords_r;
  logic [63:0]    epoch_r;
  logic [31:0]    under_r;
  logic [63:0]    pos_r;
  logic [6:0]     copied_r;
  logic [6:0]     k_r;

  // buffer tables
  logic [17:0] ent_frames [ENTRY_DEPTH];
  logic [17:0] ent_off    [ENTRY_DEPTH];
  logic [1:0]  ent_ch     [ENTRY_DEPTH];
  logic [18:0] ent_rate   [ENTRY_DEPTH];
  logic [63:0] ent_pts    [ENTRY_DEPTH];
  logic [17:0] hd_frames_q, hd_off_q;
  logic [1:0]  hd_ch_q;
  logic [18:0] hd_rate_q;
  logic [63:0] hd_pts_q;

  logic [31:0] store_mem [STORE_WORDS];
  logic [31:0] store_q;
  logic [SAW-1:0] store_raddr;
  logic [31:0] sa_r;

  logic [63:0] fbuf_mem [READ_FRAMES];
  logic [63:0] fbuf_q;

  logic [OUT_DATA_W-1:0] odata_r;
  logic [2:0]            ouser_r;
  logic                  olast_r;
  logic                  ovalid_r;
  logic                  out_free;

  // request unpacking
  logic [6:0] nreq;
  assign nreq = in_tdata[229:223];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r   <= in_tuser;
      gen_r   <= in_tdata[63:0];
      fc_r    <= in_tdata[81:64];
      ch_r    <= in_tdata[83:82];
      bytes_r <= in_tdata[107:84];
      rate_r  <= in_tdata[126:108];
      pts_r   <= in_tdata[190:127];
      word_r  <= in_tdata[222:191];
      n_r     <= (nreq > 7'(READ_FRAMES)) ? 7'(READ_FRAMES) : nreq;
    end
  end

  // enqueue checks
  logic [17:0]    limit;
  logic [19:0]    fc_ch;
  logic [21:0]    need_bytes;
  logic           bad_hdr, no_room;
  logic [2:0]     enq_status;
  logic [EIW:0]   tail_sum;
  logic [EIW-1:0] tail_idx;

  assign limit      = (max_r == 18'd0) ? 18'd1 : max_r;
  assign fc_ch      = {2'b00, fc_r} * {18'b0, ch_r};
  assign need_bytes = {fc_ch, 2'b00};
  assign bad_hdr    = (fc_r == 18'd0) || (ch_r == 2'd0) || (int'(ch_r) > MAX_CHANNELS) ||
                      (rate_r == 19'd0) || (bytes_r < {2'b00, need_bytes});
  assign no_room    = ({1'b0, queued_r} + {1'b0, fc_r} > {1'b0, limit}) ||
                      (used_r == EUW'(ENTRY_DEPTH)) ||
                      (32'(uwords_r) + 32'(fc_ch) > 32'(STORE_WORDS));

  always_comb begin
    if (gen_r != epoch_r) begin
      enq_status = ST_STALE;
    end else if (bad_hdr) begin
      enq_status = ST_INVALID;
    end else if (no_room) begin
      enq_status = ST_NO_ROOM;
    end else begin
      enq_status = ST_ACCEPTED;
    end
  end

  assign tail_sum = (EIW + 1)'(head_r) + (EIW + 1)'(used_r);
  assign tail_idx = (tail_sum >= (EIW + 1)'(ENTRY_DEPTH)) ?
                    EIW'(tail_sum - (EIW + 1)'(ENTRY_DEPTH)) : EIW'(tail_sum);

  logic enq_ok;
  assign enq_ok = cmd.enq_do && (enq_status == ST_ACCEPTED);

  // head entry arithmetic
  logic [17:0]    hd_rem;
  logic [19:0]    rem_words;
  logic [17:0]    off_inc;
  logic           hd_finished;
  logic [EIW-1:0] head_inc;
  logic [SAW:0]   drop_sum, step_sum, b_sum;
  logic [SAW-1:0] rptr_drop, rptr_step, rptr_b;

  assign hd_rem      = hd_frames_q - hd_off_q;
  assign rem_words   = {2'b00, hd_rem} * {18'b0, hd_ch_q};
  assign off_inc     = hd_off_q + 18'd1;
  assign hd_finished = off_inc >= hd_frames_q;
  assign head_inc    = (head_r == EIW'(ENTRY_DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign drop_sum  = (SAW + 1)'(rptr_r) + (SAW + 1)'(rem_words);
  assign rptr_drop = (drop_sum >= (SAW + 1)'(STORE_WORDS)) ?
                     SAW'(drop_sum - (SAW + 1)'(STORE_WORDS)) : SAW'(drop_sum);
  assign step_sum  = (SAW + 1)'(rptr_r) + (SAW + 1)'(ch_r);
  assign rptr_step = (step_sum >= (SAW + 1)'(STORE_WORDS)) ?
                     SAW'(step_sum - (SAW + 1)'(STORE_WORDS)) : SAW'(step_sum);
  assign b_sum     = (SAW + 1)'(rptr_r) + (SAW + 1)'(1);
  assign rptr_b    = (b_sum >= (SAW + 1)'(STORE_WORDS)) ? '0 : SAW'(b_sum);

  // media position divider
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVIDEND_W-1:0] quotient;
  logic                  div_done;

  assign dividend = {20'b0, hd_off_q} * {18'b0, US_PER_S};

  afbq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (hd_rate_q),
    .done     (div_done),
    .quotient (quotient)
  );

  // control state of the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= 18'd96000;
      head_r    <= '0;
      used_r    <= '0;
      wptr_r    <= '0;
      rptr_r    <= '0;
      queued_r  <= '0;
      pending_r <= '0;
      uwords_r  <= '0;
      epoch_r   <= '0;
      under_r   <= '0;
      pos_r     <= '0;
      copied_r  <= '0;
      k_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (cmd.word_write && (pending_r != 32'd0)) begin
        wptr_r    <= (wptr_r == SAW'(STORE_WORDS - 1)) ? '0 : wptr_r + 1'b1;
        pending_r <= pending_r - 32'd1;
      end
      if (enq_ok) begin
        used_r    <= used_r + 1'b1;
        queued_r  <= queued_r + fc_r;
        pending_r <= pending_r + 32'(fc_ch);
        uwords_r  <= uwords_r + SUW'(fc_ch);
      end
      if (cmd.flush_do) begin
        head_r    <= '0;
        used_r    <= '0;
        wptr_r    <= '0;
        rptr_r    <= '0;
        queued_r  <= '0;
        pending_r <= '0;
        uwords_r  <= '0;
        epoch_r   <= gen_r;
        under_r   <= '0;
        pos_r     <= '0;
      end
      if (cmd.read_start) begin
        copied_r <= '0;
        k_r      <= '0;
      end
      // drop a buffer of the wrong channel count
      if (cmd.drop) begin
        queued_r <= queued_r - hd_rem;
        rptr_r   <= rptr_drop;
        uwords_r <= uwords_r - SUW'(rem_words);
        head_r   <= head_inc;
        used_r   <= used_r - 1'b1;
      end
      if (cmd.pos_set) begin
        pos_r <= hd_pts_q + {{(64 - DIVIDEND_W){1'b0}}, quotient};
      end
      // one frame copied out of the head buffer
      if (cmd.frame_wr) begin
        copied_r <= copied_r + 7'd1;
        queued_r <= queued_r - 18'd1;
        uwords_r <= uwords_r - SUW'(ch_r);
        rptr_r   <= rptr_step;
        if (hd_finished) begin
          head_r <= head_inc;
          used_r <= used_r - 1'b1;
        end
      end
      if (cmd.rd_end && (copied_r < n_r) && (under_r != 32'hFFFF_FFFF)) begin
        under_r <= under_r + 32'd1;
      end
      if (cmd.emit_load) begin
        k_r <= k_r + 7'd1;
      end
    end
  end

  // buffer table writes and registered head read
  always_ff @(posedge clk) begin
    if (enq_ok) begin
      ent_frames[tail_idx] <= fc_r;
      ent_ch[tail_idx]     <= ch_r;
      ent_rate[tail_idx]   <= rate_r;
      ent_pts[tail_idx]    <= pts_r;
    end
    if (enq_ok) begin
      ent_off[tail_idx] <= '0;
    end else if (cmd.frame_wr) begin
      ent_off[head_r] <= off_inc;
    end
    hd_frames_q <= ent_frames[head_r];
    hd_off_q    <= ent_off[head_r];
    hd_ch_q     <= ent_ch[head_r];
    hd_rate_q   <= ent_rate[head_r];
    hd_pts_q    <= ent_pts[head_r];
  end

  // sample store
  assign store_raddr = cmd.fetch_b ? rptr_b : rptr_r;

  always_ff @(posedge clk) begin
    if (cmd.word_write && (pending_r != 32'd0)) begin
      store_mem[wptr_r] <= word_r;
    end
    store_q <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_b) begin
      sa_r <= store_q;
    end
  end

  // frame buffer of one read
  always_ff @(posedge clk) begin
    if (cmd.frame_wr) begin
      fbuf_mem[copied_r[FBW-1:0]] <= {(ch_r >= 2'd2) ? store_q : 32'd0, sa_r};
    end
    if (cmd.emit_rd) begin
      fbuf_q <= fbuf_mem[k_r[FBW-1:0]];
    end
  end

  // result register
  logic        k_filled, k_last;
  logic [17:0] enq_depth;

  assign out_free  = !ovalid_r || out_tready;
  assign k_filled  = k_r < copied_r;
  assign k_last    = (k_r + 7'd1) == n_r;
  assign enq_depth = enq_ok ? queued_r + fc_r : queued_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.enq_do || cmd.flush_do || cmd.emit_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_do) begin
      ouser_r <= enq_status;
      olast_r <= 1'b1;
      odata_r <= {6'b0, pos_r, enq_depth, under_r, 7'd0, 1'b0, 64'd0};
    end else if (cmd.flush_do) begin
      ouser_r <= ST_ACCEPTED;
      olast_r <= 1'b1;
      odata_r <= '0;
    end else if (cmd.emit_load) begin
      ouser_r <= ST_FRAME;
      olast_r <= k_last;
      odata_r <= {6'b0, pos_r, queued_r, under_r, k_last ? copied_r : 7'd0, k_filled,
                  k_filled ? fbuf_q : 64'd0};
    end
  end

  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;
  assign out_tvalid = ovalid_r;

  // status towards the controller
  assign stat.cmd          = cmd_r;
  assign stat.read_nothing = (n_r == 7'd0) || (ch_r == 2'd0);
  assign stat.rd_done      = (copied_r == n_r) || (used_r == '0);
  assign stat.head_match   = hd_ch_q == ch_r;
  assign stat.first_copy   = copied_r == 7'd0;
  assign stat.div_done     = div_done;
  assign stat.out_free     = out_free;
  assign stat.emit_last    = k_last;

endmodule
`default_nettype wire

[hdl/audio_frame_buffer_queue.sv]
// top level of the audio frame buffer queue
//
// Queue of audio sample buffers with a flush epoch. Requests arrive one at
// a time on the in_ stream: tuser selects enqueue header, sample word, read
// or flush. Enqueue and flush each give one result, waiting while the
// result register is stalled; a sample word gives none. A read walks the
// head buffers, dropping those of the wrong channel count; each copied
// frame takes two registered reads of the sample store, which has a single
// read port, the first matching buffer adds a bit-serial division for the
// media position, and the frames are then handed out one at a time,
// waiting while the output is stalled, zero frames filling a short read.
// The sample store and buffer tables are not cleared at reset, and a read
// does not wait for the sample words of an enqueued buffer to be pushed.
`default_nettype none
module audio_frame_buffer_queue
  import afbq_pkg::*;
#(
  parameter int ENTRY_DEPTH  = 16,
  parameter int STORE_WORDS  = 262144,
  parameter int MAX_CHANNELS = 2,
  parameter int READ_FRAMES  = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // generation, frame_count, channels, byte_length, sample_rate, pts_us,
  // sample_word, requested_frames
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // sample_first, sample_second, frame_filled, frames_copied, underrun_count,
  // depth_frames, media_position_us
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [17:0]           cfg_wr_data
);

  afbq_cmd_t  cmd;
  afbq_stat_t stat;

  afbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  afbq_datapath #(
    .ENTRY_DEPTH  (ENTRY_DEPTH),
    .STORE_WORDS  (STORE_WORDS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .READ_FRAMES  (READ_FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
`default_nettype wire
